// ===== rtl/vthm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the value to heatmap RGB core.
package vthm_pkg;

    localparam int VALUE_W   = 18;
    localparam int CH_W      = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 1;

    // Accept edge to the edge that samples the result strobe.
    localparam int PIPE_LAT  = 9;

    localparam logic [CFG_IDX_W-1:0] REG_GRAY_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT_GRAY = 1'd1;

    // Hue sectors of the HSV wheel, 60 degrees each.
    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5
    } t_sector;

    typedef struct packed {
        logic    valid;
        logic    gray;
        logic    cyan_en;
        logic    green_en;
        logic    green_neg;
        t_sector sector;
    } t_ctl;

endpackage

// ===== rtl/vthm_hue.sv =====
`timescale 1ns / 1ps
// Input clamp, hue computation, band stretch and divider numerators (four stages).
module vthm_hue #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_accept,
    input  logic signed [vthm_pkg::VALUE_W-1:0] i_value_in,
    input  logic                               i_gray_mode,
    input  logic                               i_invert_gray,
    output vthm_pkg::t_ctl                     o_ctl,
    output logic [FRAC_BITS+5:0]               o_num_cyan,
    output logic [FRAC_BITS+5:0]               o_num_green,
    output logic [FRAC_BITS+5:0]               o_rem,
    output logic [FRAC_BITS:0]                 o_cgray
);

    localparam int XW    = FRAC_BITS + 1;
    localparam int HW    = FRAC_BITS + 8;
    localparam int NW    = FRAC_BITS + 6;
    localparam int SH_UP = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_DN = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic [XW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [HW-1:0] H35  = HW'(35)  << FRAC_BITS;
    localparam logic [HW-1:0] H50  = HW'(50)  << FRAC_BITS;
    localparam logic [HW-1:0] H57  = HW'(57)  << FRAC_BITS;
    localparam logic [HW-1:0] H60  = HW'(60)  << FRAC_BITS;
    localparam logic [HW-1:0] H100 = HW'(100) << FRAC_BITS;
    localparam logic [HW-1:0] H120 = HW'(120) << FRAC_BITS;
    localparam logic [HW-1:0] H145 = HW'(145) << FRAC_BITS;
    localparam logic [HW-1:0] H157 = HW'(157) << FRAC_BITS;
    localparam logic [HW-1:0] H165 = HW'(165) << FRAC_BITS;
    localparam logic [HW-1:0] H180 = HW'(180) << FRAC_BITS;
    localparam logic [HW-1:0] H215 = HW'(215) << FRAC_BITS;
    localparam logic [HW-1:0] H240 = HW'(240) << FRAC_BITS;

    // stage 1: clamp and scale
    logic [16:0]           clamp_v;
    logic [16+FRAC_BITS:0] scaled;
    logic [XW-1:0]         x_in;
    logic [XW-1:0]         r_s1_x, n_s1_x;
    logic [XW-1:0]         r_s1_cg, n_s1_cg;
    vthm_pkg::t_ctl        r_s1_ctl, n_s1_ctl;

    always_comb begin
        if (i_value_in[vthm_pkg::VALUE_W-1]) begin
            clamp_v = '0;
        end else if (i_value_in[16:0] > 17'd65536) begin
            clamp_v = 17'd65536;
        end else begin
            clamp_v = i_value_in[16:0];
        end
        scaled   = ({{FRAC_BITS{1'b0}}, clamp_v} << SH_UP) >> SH_DN;
        x_in     = scaled[XW-1:0];
        n_s1_x   = x_in;
        n_s1_cg  = i_invert_gray ? x_in : ONE - x_in;
        n_s1_ctl = '0;
        n_s1_ctl.valid = i_accept;
        n_s1_ctl.gray  = i_gray_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
        end
        r_s1_x  <= n_s1_x;
        r_s1_cg <= n_s1_cg;
    end

    // stage 2: hue = (1 - x) * 192, band flags
    logic [XW-1:0]  dx;
    logic [HW-1:0]  r_s2_h, n_s2_h;
    logic           r_s2_str, n_s2_str;
    logic           r_s2_over, n_s2_over;
    logic [XW-1:0]  r_s2_cg;
    vthm_pkg::t_ctl r_s2_ctl;

    always_comb begin
        dx        = ONE - r_s1_x;
        n_s2_h    = {dx, 7'b0} + HW'({dx, 6'b0});
        n_s2_str  = (n_s2_h >= H145) && (n_s2_h <= H165);
        n_s2_over = n_s2_h > H165;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl <= r_s1_ctl;
        end
        r_s2_h    <= n_s2_h;
        r_s2_str  <= n_s2_str;
        r_s2_over <= n_s2_over;
        r_s2_cg   <= r_s1_cg;
    end

    // stage 3: stretch cyan band by 3.5, shift hues above it up by 50
    logic [HW-1:0]  dh, seven;
    logic [HW-1:0]  r_s3_h, n_s3_h;
    logic           r_s3_str;
    logic [XW-1:0]  r_s3_cg;
    vthm_pkg::t_ctl r_s3_ctl;

    always_comb begin
        dh    = r_s2_h - H145;
        seven = (dh << 3) - dh;
        if (r_s2_str) begin
            n_s3_h = H145 + (seven >> 1);
        end else if (r_s2_over) begin
            n_s3_h = r_s2_h + H50;
        end else begin
            n_s3_h = r_s2_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_ctl <= '0;
        end else begin
            r_s3_ctl <= r_s2_ctl;
        end
        r_s3_h   <= n_s3_h;
        r_s3_str <= r_s2_str;
        r_s3_cg  <= r_s2_cg;
    end

    // stage 4: dimming numerators, sector and remainder
    logic [HW-1:0]  gd, cd, gmag, cnum, offs, remh;
    logic           gneg;
    vthm_pkg::t_ctl n_s4_ctl, r_s4_ctl;
    logic [NW-1:0]  r_s4_nc, r_s4_ng, r_s4_rem;
    logic [XW-1:0]  r_s4_cg;

    always_comb begin
        gd = (r_s3_h >= H157) ? r_s3_h - H157 : H157 - r_s3_h;
        if (gd <= H57) begin
            gmag = H57 - gd;
            gneg = 1'b0;
        end else begin
            gmag = gd - H57;
            gneg = 1'b1;
        end
        cd   = (r_s3_h >= H180) ? r_s3_h - H180 : H180 - r_s3_h;
        cnum = r_s3_str ? H35 - cd : '0;

        n_s4_ctl           = r_s3_ctl;
        n_s4_ctl.cyan_en   = r_s3_str;
        n_s4_ctl.green_en  = (r_s3_h >= H100) && (r_s3_h <= H215);
        n_s4_ctl.green_neg = gneg;
        if (r_s3_h >= H240) begin
            n_s4_ctl.sector = vthm_pkg::SEC_BLU_MAG;
            offs            = H240;
        end else if (r_s3_h >= H180) begin
            n_s4_ctl.sector = vthm_pkg::SEC_CYN_BLU;
            offs            = H180;
        end else if (r_s3_h >= H120) begin
            n_s4_ctl.sector = vthm_pkg::SEC_GRN_CYN;
            offs            = H120;
        end else if (r_s3_h >= H60) begin
            n_s4_ctl.sector = vthm_pkg::SEC_YEL_GRN;
            offs            = H60;
        end else begin
            n_s4_ctl.sector = vthm_pkg::SEC_RED_YEL;
            offs            = '0;
        end
        remh = r_s3_h - offs;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_ctl <= '0;
        end else begin
            r_s4_ctl <= n_s4_ctl;
        end
        r_s4_nc  <= cnum[NW-1:0];
        r_s4_ng  <= gmag[NW-1:0];
        r_s4_rem <= remh[NW-1:0];
        r_s4_cg  <= r_s3_cg;
    end

    assign o_ctl       = r_s4_ctl;
    assign o_num_cyan  = r_s4_nc;
    assign o_num_green = r_s4_ng;
    assign o_rem       = r_s4_rem;
    assign o_cgray     = r_s4_cg;

endmodule

// ===== rtl/vthm_cdiv.sv =====
`timescale 1ns / 1ps
// Two-stage divide by a constant: reciprocal multiply, then one correction step.
module vthm_cdiv #(
    parameter int W       = 22,
    parameter int DIVISOR = 175
) (
    input  logic         i_clk,
    input  logic [W-1:0] i_a,
    output logic [W-1:0] o_q
);

    localparam int            PW    = 2 * W;
    localparam logic [W-1:0]  RCP   = W'((64'd1 << W) / DIVISOR);
    localparam logic [W-1:0]  DIV_W = W'(DIVISOR);

    // estimate is exact or one short
    logic [PW-1:0] prod;
    logic [W-1:0]  r_a, r_q0;
    logic [W-1:0]  qd, rr;
    logic [W-1:0]  r_q, n_q;

    always_comb begin
        prod = PW'(i_a) * PW'(RCP);
        qd   = r_q0 * DIV_W;
        rr   = r_a - qd;
        n_q  = (rr >= DIV_W) ? r_q0 + W'(1) : r_q0;
    end

    always_ff @(posedge i_clk) begin
        r_a  <= i_a;
        r_q0 <= prod[PW-1:W];
        r_q  <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== rtl/vthm_hsv.sv =====
`timescale 1ns / 1ps
// Brightness, HSV sector products and channel scaling (three stages).
module vthm_hsv #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vthm_pkg::t_ctl              i_ctl,
    input  logic [FRAC_BITS:0]          i_cgray,
    input  logic [FRAC_BITS+5:0]        i_q_cyan,
    input  logic [FRAC_BITS+5:0]        i_q_green,
    input  logic [FRAC_BITS+5:0]        i_q_ff,
    output logic                        o_valid,
    output logic [vthm_pkg::CH_W-1:0]   o_red,
    output logic [vthm_pkg::CH_W-1:0]   o_green,
    output logic [vthm_pkg::CH_W-1:0]   o_blue
);

    localparam int XW = FRAC_BITS + 1;
    localparam int PW = 2 * XW;
    localparam logic [XW-1:0]        ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [XW+1:0] ONE_S = $signed({2'b00, ONE});

    function automatic logic [vthm_pkg::CH_W-1:0] to_ch(input logic [XW-1:0] c);
        logic [XW+7:0] p;
        logic [XW+7:0] s;
        p = {c, 8'b0} - (XW+8)'(c);
        s = p >> FRAC_BITS;
        return (s > (XW+8)'(255)) ? 8'hFF : s[7:0];
    endfunction

    // stage 1: v = 1 - cyan dim - green dim (green term is signed)
    logic signed [XW+1:0] tc, tg, sv;
    logic [XW-1:0]        r_v, n_v;
    logic [FRAC_BITS-1:0] r_ff;
    logic [XW-1:0]        r_s1_cg;
    vthm_pkg::t_ctl       r_s1_ctl;

    always_comb begin
        tc = i_ctl.cyan_en ? $signed({2'b00, i_q_cyan[XW-1:0]}) : '0;
        if (!i_ctl.green_en) begin
            tg = '0;
        end else if (i_ctl.green_neg) begin
            tg = -$signed({2'b00, i_q_green[XW-1:0]});
        end else begin
            tg = $signed({2'b00, i_q_green[XW-1:0]});
        end
        sv  = ONE_S - tc - tg;
        n_v = sv[XW+1] ? '0 : sv[XW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= i_ctl;
        end
        r_v     <= n_v;
        r_ff    <= i_q_ff[FRAC_BITS-1:0];
        r_s1_cg <= i_cgray;
    end

    // stage 2: t = v*ff, q = v*(1-ff)
    logic [XW-1:0]  omf;
    logic [PW-1:0]  pt, pq;
    logic [XW-1:0]  r_v2, r_t, r_q;
    logic [XW-1:0]  r_s2_cg;
    vthm_pkg::t_ctl r_s2_ctl;

    always_comb begin
        omf = ONE - {1'b0, r_ff};
        pt  = PW'(r_v) * PW'({1'b0, r_ff});
        pq  = PW'(r_v) * PW'(omf);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else begin
            r_s2_ctl <= r_s1_ctl;
        end
        r_v2    <= r_v;
        r_t     <= pt[FRAC_BITS +: XW];
        r_q     <= pq[FRAC_BITS +: XW];
        r_s2_cg <= r_s1_cg;
    end

    // stage 3: sector select, channel scaling, output register
    logic [XW-1:0]               cr, cg, cb;
    logic                        r_valid;
    logic [vthm_pkg::CH_W-1:0]   r_red, r_green, r_blue;

    always_comb begin
        unique case (r_s2_ctl.sector)
            vthm_pkg::SEC_RED_YEL: begin cr = r_v2; cg = r_t;  cb = '0;   end
            vthm_pkg::SEC_YEL_GRN: begin cr = r_q;  cg = r_v2; cb = '0;   end
            vthm_pkg::SEC_GRN_CYN: begin cr = '0;   cg = r_v2; cb = r_t;  end
            vthm_pkg::SEC_CYN_BLU: begin cr = '0;   cg = r_q;  cb = r_v2; end
            vthm_pkg::SEC_BLU_MAG: begin cr = r_t;  cg = '0;   cb = r_v2; end
            default:               begin cr = r_v2; cg = '0;   cb = r_q;  end
        endcase
        if (r_s2_ctl.gray) begin
            cr = r_s2_cg;
            cg = r_s2_cg;
            cb = r_s2_cg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_s2_ctl.valid;
        end
        r_red   <= to_ch(cr);
        r_green <= to_ch(cg);
        r_blue  <= to_ch(cb);
    end

    assign o_valid = r_valid;
    assign o_red   = r_red;
    assign o_green = r_green;
    assign o_blue  = r_blue;

endmodule

// ===== rtl/value_to_heatmap_rgb_core.sv =====
`timescale 1ns / 1ps
// A beat accepted with start high and busy low comes back as a result with o_valid.
// Throughput: one beat per cycle out of reset; nine fixed register stages, no loop or shared unit.
// The slowest stages are the reciprocal multiplies and the v*ff products (one each).
// Reset (i_rst_n low, synchronous) clears all valid bits and both config registers;
// busy is high only while reset is held. The receiver cannot stall.
module value_to_heatmap_rgb_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [vthm_pkg::VALUE_W-1:0]   i_value_in,
    input  logic                                  i_cfg_we,
    input  logic [vthm_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [vthm_pkg::CFG_DAT_W-1:0]        i_cfg_wdata,
    output logic                                  o_valid,
    output logic [vthm_pkg::CH_W-1:0]             o_red,
    output logic [vthm_pkg::CH_W-1:0]             o_green,
    output logic [vthm_pkg::CH_W-1:0]             o_blue
);

    localparam int XW = FRAC_BITS + 1;
    localparam int NW = FRAC_BITS + 6;

    // Config registers. Only bit 0 of the write data counts.
    logic r_gray_mode, n_gray_mode;
    logic r_invert_gray, n_invert_gray;

    always_comb begin
        n_gray_mode   = r_gray_mode;
        n_invert_gray = r_invert_gray;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vthm_pkg::REG_GRAY_MODE:   n_gray_mode   = i_cfg_wdata[0];
                vthm_pkg::REG_INVERT_GRAY: n_invert_gray = i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray_mode   <= 1'b0;
            r_invert_gray <= 1'b0;
        end else begin
            r_gray_mode   <= n_gray_mode;
            r_invert_gray <= n_invert_gray;
        end
    end

    // No backpressure: every cycle out of reset takes a beat.
    assign busy = ~i_rst_n;

    // Stages 1-4: clamp, hue, stretch, numerators.
    vthm_pkg::t_ctl hue_ctl;
    logic [NW-1:0]  num_cyan, num_green, rem;
    logic [XW-1:0]  hue_cg;

    vthm_hue #(.FRAC_BITS(FRAC_BITS)) u_hue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (start & ~busy),
        .i_value_in    (i_value_in),
        .i_gray_mode   (r_gray_mode),
        .i_invert_gray (r_invert_gray),
        .o_ctl         (hue_ctl),
        .o_num_cyan    (num_cyan),
        .o_num_green   (num_green),
        .o_rem         (rem),
        .o_cgray       (hue_cg)
    );

    // Stages 5-6: three constant dividers in parallel (/175, /285, /60).
    logic [NW-1:0] q_cyan, q_green, q_ff;

    vthm_cdiv #(.W(NW), .DIVISOR(175)) u_div_cyan (
        .i_clk (i_clk),
        .i_a   (num_cyan),
        .o_q   (q_cyan)
    );

    vthm_cdiv #(.W(NW), .DIVISOR(285)) u_div_green (
        .i_clk (i_clk),
        .i_a   (num_green),
        .o_q   (q_green)
    );

    vthm_cdiv #(.W(NW), .DIVISOR(60)) u_div_ff (
        .i_clk (i_clk),
        .i_a   (rem),
        .o_q   (q_ff)
    );

    // Control and gray level ride alongside the dividers.
    vthm_pkg::t_ctl r_ctl_d [2];
    logic [XW-1:0]  r_cg_d  [2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl_d[0] <= '0;
            r_ctl_d[1] <= '0;
        end else begin
            r_ctl_d[0] <= hue_ctl;
            r_ctl_d[1] <= r_ctl_d[0];
        end
        r_cg_d[0] <= hue_cg;
        r_cg_d[1] <= r_cg_d[0];
    end

    // Stages 7-9: brightness, sector products, channels.
    vthm_hsv #(.FRAC_BITS(FRAC_BITS)) u_hsv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_ctl_d[1]),
        .i_cgray   (r_cg_d[1]),
        .i_q_cyan  (q_cyan),
        .i_q_green (q_green),
        .i_q_ff    (q_ff),
        .o_valid   (o_valid),
        .o_red     (o_red),
        .o_green   (o_green),
        .o_blue    (o_blue)
    );

endmodule

// ===== rtl/vthm_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the heatmap core and its bind.
module vthm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                start,
    input logic                                busy,
    input logic                                i_cfg_we,
    input logic [vthm_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input logic [vthm_pkg::CFG_DAT_W-1:0]      i_cfg_wdata,
    input logic                                o_valid,
    input logic [vthm_pkg::CH_W-1:0]           o_red,
    input logic [vthm_pkg::CH_W-1:0]           o_green,
    input logic [vthm_pkg::CH_W-1:0]           o_blue
);

    // mirror of the gray mode bit as seen on the config port
    logic r_gray;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gray <= 1'b0;
        end else if (i_cfg_we && (i_cfg_idx == vthm_pkg::REG_GRAY_MODE)) begin
            r_gray <= i_cfg_wdata[0];
        end
    end

    a_lat_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##(vthm_pkg::PIPE_LAT) o_valid)
        else $error("accepted beat produced no result");

    a_lat_bwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, vthm_pkg::PIPE_LAT))
        else $error("result without matching beat");

    a_gray_eq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_gray) |-> ((o_red == o_green) && (o_green == o_blue)))
        else $error("gray result channels differ");

    a_color_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !r_gray) |-> ((o_red == '0) || (o_green == '0) || (o_blue == '0)))
        else $error("color result has no zero channel");

endmodule

bind value_to_heatmap_rgb_core vthm_checker u_vthm_checker (.*);

// ===== tb/tb_value_to_heatmap_rgb_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for value_to_heatmap_rgb_core: directed and random values in all modes.
module tb_value_to_heatmap_rgb_core;

    localparam int FRAC_BITS = 16;
    localparam int RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [vthm_pkg::CH_W-1:0] red;
        logic [vthm_pkg::CH_W-1:0] green;
        logic [vthm_pkg::CH_W-1:0] blue;
    } t_rgb;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [vthm_pkg::VALUE_W-1:0] i_value_in;
    logic                                i_cfg_we;
    logic [vthm_pkg::CFG_IDX_W-1:0]      i_cfg_idx;
    logic [vthm_pkg::CFG_DAT_W-1:0]      i_cfg_wdata;
    logic                                o_valid;
    logic [vthm_pkg::CH_W-1:0]           o_red;
    logic [vthm_pkg::CH_W-1:0]           o_green;
    logic [vthm_pkg::CH_W-1:0]           o_blue;

    // Local copy of the two mode registers, updated as they are written.
    bit gray_cfg;
    bit inv_cfg;

    // Expected colors, oldest first; one entry per accepted beat.
    t_rgb pending_rgb[$];
    t_rgb want_rgb;
    int   err_cnt;
    bit   gaps_on;

    // Hue and sector corners in Q16: h = 145, 165 (h' = 215), 100, 120, 60, h' = 180.
    int hue_pts[10] = '{0, 65536, 9216, 16042, 16043, 31402, 31403, 24576, 45056, 12629};

    value_to_heatmap_rgb_core #(
        .FRAC_BITS (FRAC_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value_in  (i_value_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_valid     (o_valid),
        .o_red       (o_red),
        .o_green     (o_green),
        .o_blue      (o_blue)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Color predictor
    // ---------------------------------------------------------------

    // Scale a Q.F intensity to 8 bits, truncating and saturating.
    function automatic logic [vthm_pkg::CH_W-1:0] level8(input longint c);
        longint r;
        if (c <= 0)
            return '0;
        r = (c * 255) >>> FRAC_BITS;
        if (r > 255)
            r = 255;
        return r[vthm_pkg::CH_W-1:0];
    endfunction

    function automatic longint mag(input longint a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic t_rgb heatmap_rgb(input logic signed [vthm_pkg::VALUE_W-1:0] val,
                                         input bit gray, input bit inv);
        longint  one, s, x, h, v, sec, rem, ff, t, q, cr, cg, cb;
        vthm_pkg::t_sector sec_e;
        logic [vthm_pkg::CH_W-1:0] c;
        t_rgb    res;
        one = longint'(1) << FRAC_BITS;
        s = longint'(val);
        // clamp to 0.0 .. 1.0 before rescaling to Q.F
        if (s < 0)
            s = 0;
        if (s > 65536)
            s = 65536;
        if (FRAC_BITS >= 16)
            x = s << (FRAC_BITS - 16);
        else
            x = s >>> (16 - FRAC_BITS);

        if (gray) begin
            if (inv)
                x = one - x;
            c = level8(one - x);
            res = '{red: c, green: c, blue: c};
            return res;
        end

        h = (one - x) * 192;
        v = one;
        // cyan band stretched over 145..215 and dimmed; above it shifted by 50
        if (h >= 145 * one && h <= 165 * one) begin
            h = 145 * one + ((h - 145 * one) * 70) / 20;
            v = v - (35 * one - mag(h - 180 * one)) / 175;
        end else if (h > 165 * one) begin
            h = h + 50 * one;
        end
        // green dim, signed: may lift v a little near 215
        if (h >= 100 * one && h <= 215 * one)
            v = v - (57 * one - mag(h - 157 * one)) / 285;
        if (h >= 360 * one)
            h = 0;
        sec = h / (60 * one);
        rem = h - sec * (60 * one);
        ff = rem / 60;
        if (v < 0)
            v = 0;
        t = (v * ff) >>> FRAC_BITS;
        q = (v * (one - ff)) >>> FRAC_BITS;
        if (sec > 5)
            sec = 5;
        sec_e = vthm_pkg::t_sector'(sec[2:0]);
        case (sec_e)
            vthm_pkg::SEC_RED_YEL: begin cr = v; cg = t; cb = 0; end
            vthm_pkg::SEC_YEL_GRN: begin cr = q; cg = v; cb = 0; end
            vthm_pkg::SEC_GRN_CYN: begin cr = 0; cg = v; cb = t; end
            vthm_pkg::SEC_CYN_BLU: begin cr = 0; cg = q; cb = v; end
            vthm_pkg::SEC_BLU_MAG: begin cr = t; cg = 0; cb = v; end
            default: begin cr = v; cg = 0; cb = q; end
        endcase
        res = '{red: level8(cr), green: level8(cg), blue: level8(cb)};
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Result checker: every strobe is matched against the oldest entry
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_rgb.size() == 0) begin
                if (err_cnt < 10)
                    $display("unexpected result beat r=%0d g=%0d b=%0d",
                             o_red, o_green, o_blue);
                err_cnt++;
            end else begin
                want_rgb = pending_rgb.pop_front();
                if (o_red !== want_rgb.red || o_green !== want_rgb.green
                        || o_blue !== want_rgb.blue) begin
                    if (err_cnt < 10)
                        $display("color mismatch: exp r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 want_rgb.red, want_rgb.green, want_rgb.blue,
                                 o_red, o_green, o_blue);
                    err_cnt++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Shared driving tasks
    // ---------------------------------------------------------------

    // One input beat; start stays high into the next call unless a gap is taken.
    task automatic send_value(input logic signed [vthm_pkg::VALUE_W-1:0] val);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start      <= 1'b1;
        i_value_in <= val;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        pending_rgb.push_back(heatmap_rgb(val, gray_cfg, inv_cfg));
    endtask

    // Stop sending and wait until every expected color has come back.
    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_rgb.size() != 0)
            @(posedge i_clk);
    endtask

    // Writes both mode registers; called only with the pipeline empty.
    task automatic set_mode(input bit gray, input bit inv);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= vthm_pkg::REG_GRAY_MODE;
        i_cfg_wdata <= gray;
        @(posedge i_clk);
        gray_cfg     = gray;
        i_cfg_idx   <= vthm_pkg::REG_INVERT_GRAY;
        i_cfg_wdata <= inv;
        @(posedge i_clk);
        inv_cfg      = inv;
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly in-range values, some near hue corners, some over the full 18 bits.
    function automatic logic signed [vthm_pkg::VALUE_W-1:0] pick_value();
        int                            sel;
        logic [vthm_pkg::VALUE_W-1:0]  raw;
        sel = $urandom_range(0, 99);
        raw = vthm_pkg::VALUE_W'($urandom());
        if (sel < 12)
            return raw;
        if (sel < 25)
            return vthm_pkg::VALUE_W'(hue_pts[$urandom_range(0, 9)]
                                      + int'($urandom_range(0, 8)) - 4);
        return vthm_pkg::VALUE_W'($urandom_range(0, 65536));
    endfunction

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Clamp extremes, band edges, sector edges and the saturating channel.
    task automatic test_color_edges();
        int pts[18] = '{-131072, -1, 0, 1, 65535, 65536, 65537, 131071,
                        9215, 9216, 9217, 12629, 16042, 16043,
                        31402, 31403, 24576, 45056};
        set_mode(1'b0, 1'b0);
        foreach (pts[k])
            send_value(vthm_pkg::VALUE_W'(pts[k]));
        settle();
    endtask

    // Gray ramp ends and clamping, plain and inverted.
    task automatic test_gray_edges();
        int pts[4] = '{-131072, 0, 32768, 131071};
        set_mode(1'b1, 1'b0);
        foreach (pts[k])
            send_value(vthm_pkg::VALUE_W'(pts[k]));
        settle();
        set_mode(1'b1, 1'b1);
        foreach (pts[k])
            send_value(vthm_pkg::VALUE_W'(pts[k]));
        settle();
    endtask

    // Random values under one mode setting; nogap_len beats run back to back.
    task automatic test_random_mode(input bit gray, input bit inv, input int n,
                                    input int nogap_len);
        set_mode(gray, inv);
        for (int k = 0; k < n; k++) begin
            gaps_on = !(k >= n / 3 && k < n / 3 + nogap_len);
            send_value(pick_value());
        end
        gaps_on = 1'b1;
        settle();
    endtask

    // Mode changes between short bursts, each burst under a random one of the four settings.
    task automatic test_mode_hops(input int bursts);
        for (int b = 0; b < bursts; b++) begin
            set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            repeat ($urandom_range(1, 20))
                send_value(pick_value());
            settle();
        end
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_value_in  <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= vthm_pkg::REG_GRAY_MODE;
        i_cfg_wdata <= '0;
        gray_cfg     = 1'b0;
        inv_cfg      = 1'b0;
        err_cnt      = 0;
        gaps_on      = 1'b1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_color_edges();
        test_gray_edges();
        test_random_mode(1'b0, 1'b0, 650, 250);
        test_random_mode(1'b0, 1'b1, 250, 0);
        test_random_mode(1'b1, 1'b0, 250, 0);
        test_random_mode(1'b1, 1'b1, 250, 0);
        test_mode_hops(30);

        settle();
        repeat (vthm_pkg::PIPE_LAT + 4) @(posedge i_clk);
        if (pending_rgb.size() != 0)
            err_cnt++;
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #(RUN_LIMIT_NS);
        $display("== FAIL ==");
        $finish;
    end

endmodule
